[src/async_value_iteration_solver_macros.svh]
// Assertion macros used by the solver core.
`ifndef ASYNC_VALUE_ITERATION_SOLVER_MACROS_SVH
`define ASYNC_VALUE_ITERATION_SOLVER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AVIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define AVIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/avis_pkg.sv]
package avis_pkg;

    // Sizes
    localparam int MAX_STATES  = 4096;
    localparam int ST_W        = 12;
    localparam int ACT_W       = 4;
    localparam int MAX_TRANS   = 16384;
    localparam int TR_AW       = 14;
    localparam int TRC_W       = 15;
    localparam int ACC_W       = 48;

    // Command codes
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_SOLVE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_STAR_COUNT   = 3'd0;
    localparam logic [2:0] REG_STATE_COUNT  = 3'd1;
    localparam logic [2:0] REG_ACTION_COUNT = 3'd2;
    localparam logic [2:0] REG_DISCOUNT     = 3'd3;
    localparam logic [2:0] REG_TOLERANCE    = 3'd4;
    localparam logic [2:0] REG_MAX_EPOCHS   = 3'd5;

    // Step costs in Q16.16
    localparam logic signed [31:0] COST_GOAL = -32'sd6553600;
    localparam logic signed [31:0] COST_FUEL = 32'sd6553600;
    localparam logic signed [31:0] COST_MOVE = 32'sd327680;

    typedef struct packed {
        logic [2:0]         command;
        logic [11:0]        state_index;
        logic [3:0]         action_index;
        logic [11:0]        succ_state;
        logic [16:0]        probability;
        logic signed [31:0] initial_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] state_value;
        logic [3:0]         policy_action;
        logic [15:0]        epochs_used;
        logic               converged;
        logic               load_error;
    } out_word_t;

    typedef struct packed {
        logic [ST_W-1:0]  st;
        logic [ACT_W-1:0] act;
        logic [ST_W-1:0]  nxt;
        logic [16:0]      prob;
    } trans_t;

    typedef struct packed {
        logic [6:0]  star_count;
        logic [12:0] state_count;
        logic [4:0]  action_count;
        logic [15:0] discount;
        logic [15:0] tolerance;
        logic [15:0] max_epochs;
    } cfg_t;

endpackage

[src/avis_ram.sv]
module avis_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/avis_cfg.sv]
module avis_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output avis_pkg::cfg_t cfg
);
    import avis_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.star_count   <= 7'd4;
            cfg_reg.state_count  <= 13'd64;
            cfg_reg.action_count <= 5'd4;
            cfg_reg.discount     <= 16'd64881;
            cfg_reg.tolerance    <= 16'd1;
            cfg_reg.max_epochs   <= 16'd1000;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_STAR_COUNT:   cfg_reg.star_count   <= pwdata[6:0];
                REG_STATE_COUNT:  cfg_reg.state_count  <= pwdata[12:0];
                REG_ACTION_COUNT: cfg_reg.action_count <= pwdata[4:0];
                REG_DISCOUNT:     cfg_reg.discount     <= pwdata[15:0];
                REG_TOLERANCE:    cfg_reg.tolerance    <= pwdata[15:0];
                REG_MAX_EPOCHS:   cfg_reg.max_epochs   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[4:2])
            REG_STAR_COUNT:   prdata = {25'd0, cfg_reg.star_count};
            REG_STATE_COUNT:  prdata = {19'd0, cfg_reg.state_count};
            REG_ACTION_COUNT: prdata = {27'd0, cfg_reg.action_count};
            REG_DISCOUNT:     prdata = {16'd0, cfg_reg.discount};
            REG_TOLERANCE:    prdata = {16'd0, cfg_reg.tolerance};
            REG_MAX_EPOCHS:   prdata = {16'd0, cfg_reg.max_epochs};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

[src/avis_core.sv]
`include "async_value_iteration_solver_macros.svh"

module avis_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  avis_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  avis_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output avis_pkg::out_word_t m_data
);
    import avis_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SWEEP, S_RD, S_CHK, S_ADV, S_ENT, S_V1, S_V2, S_V3,
        S_ACC, S_NXT, S_FIN1, S_FIN2, S_END
    } state_t;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
        if (x > $signed(48'h00007FFFFFFF)) return 32'sh7FFFFFFF;
        else if (x < $signed(48'hFFFF80000000)) return 32'sh80000000;
        else return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        if (x > $signed(34'h07FFFFFFF)) return 32'sh7FFFFFFF;
        else if (x < $signed(34'h380000000)) return 32'sh80000000;
        else return x[31:0];
    endfunction

    state_t             state_reg;
    logic [ST_W-1:0]    clr_cnt_reg;
    logic [TRC_W-1:0]   tr_total_reg;
    logic [ST_W-1:0]    last_st_reg;
    logic [ACT_W-1:0]   last_act_reg;
    logic [15:0]        epochs_reg;
    logic               conv_reg;
    logic               p1_v_reg, p1_rd_reg, p1_lerr_reg;
    logic               m_valid_reg;
    out_word_t          out_reg;
    // solve context
    logic [TRC_W-1:0]   ptr_reg;
    logic [15:0]        ep_reg;
    logic [32:0]        delta_reg;
    logic               grp_on_reg, ret_end_reg;
    logic [ST_W-1:0]    grp_st_reg, cnt_st_reg;
    logic [6:0]         cur_reg, goal_reg;
    logic               fuel_zero_reg;
    logic               run_on_reg, run_seen_reg;
    logic [ACT_W-1:0]   run_act_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               best_any_reg;
    logic signed [31:0] best_reg;
    logic [ACT_W-1:0]   best_act_reg;
    logic signed [32:0] dv_reg;
    logic signed [31:0] term_reg;
    logic signed [33:0] prod_reg;

    // memory ports
    trans_t             tr_q;
    trans_t             tr_wdata;
    logic               tr_we, tr_re;
    logic [31:0]        val_rdata, val_wdata;
    logic               val_we, val_re;
    logic [ST_W-1:0]    val_waddr, val_raddr;
    logic [ACT_W-1:0]   pol_rdata, pol_wdata;
    logic               pol_we;

    logic               s_fire, out_free, load_bad;
    logic [12:0]        ns;
    logic [6:0]         n_eff;
    logic [15:0]        ep_next, lim;
    logic signed [31:0] acc_sat, cost;
    logic               close_upd, ent_skip, sweep_done;
    logic signed [48:0] dv_prod;
    logic signed [49:0] pr_prod;
    logic signed [33:0] term_sum;
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && (!p1_v_reg || out_free);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    assign load_bad = (tr_total_reg >= TRC_W'(MAX_TRANS)) ||
        ((tr_total_reg != '0) && ((s_data.state_index < last_st_reg) ||
        ((s_data.state_index == last_st_reg) && (s_data.action_index < last_act_reg))));

    assign ns      = (cfg.state_count > 13'(MAX_STATES)) ? 13'(MAX_STATES) : cfg.state_count;
    assign n_eff   = (cfg.star_count == 7'd0) ? 7'd1 : cfg.star_count;
    assign lim     = (cfg.max_epochs == 16'd0) ? 16'd1 : cfg.max_epochs;
    assign ep_next = ep_reg + 16'd1;
    assign ent_skip = {1'b0, tr_q.act} >= cfg.action_count;

    // closing an action run: strict less keeps the lowest action on ties
    assign acc_sat   = sat48(acc_reg);
    assign close_upd = run_on_reg && run_seen_reg && (!best_any_reg || acc_sat < best_reg);

    // arithmetic datapath, at most one multiply per stage
    assign dv_prod  = $signed({1'b0, cfg.discount}) * $signed(val_rdata);
    assign pr_prod  = $signed({1'b0, tr_q.prob}) * term_reg;
    always_comb begin
        if ((goal_reg == cur_reg) && (tr_q.act == '0)) cost = COST_GOAL;
        else if (fuel_zero_reg) cost = COST_FUEL;
        else if (tr_q.act != '0) cost = COST_MOVE;
        else cost = 32'sd0;
    end
    assign term_sum = $signed({{2{cost[31]}}, cost}) + $signed({dv_reg[32], dv_reg});
    assign diff     = $signed({best_reg[31], best_reg}) - $signed({val_rdata[31], val_rdata});
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    assign sweep_done = (delta_reg < {17'd0, cfg.tolerance}) || (ep_next >= lim);

    // memory control
    assign tr_we    = s_fire && (s_data.command == CMD_LOAD) && !load_bad;
    assign tr_wdata = '{st: s_data.state_index, act: s_data.action_index,
                        nxt: s_data.succ_state, prob: s_data.probability};
    assign tr_re    = (state_reg == S_RD) && (ptr_reg != tr_total_reg);

    always_comb begin
        val_we    = 1'b0;
        val_waddr = s_data.state_index;
        val_wdata = s_data.initial_value;
        pol_we    = 1'b0;
        pol_wdata = best_act_reg;
        val_re    = s_fire;
        val_raddr = s_data.state_index;
        case (state_reg)
            S_CLR: begin
                val_we    = 1'b1;
                pol_we    = 1'b1;
                val_waddr = clr_cnt_reg;
                val_wdata = '0;
                pol_wdata = '0;
            end
            S_IDLE: begin
                val_we = s_fire && (s_data.command == CMD_WRITE);
            end
            S_ENT: begin
                val_re    = !ent_skip;
                val_raddr = tr_q.nxt;
            end
            S_FIN1: begin
                val_re    = 1'b1;
                val_raddr = grp_st_reg;
            end
            S_FIN2: begin
                val_we    = best_any_reg;
                pol_we    = best_any_reg;
                val_waddr = grp_st_reg;
                val_wdata = best_reg;
            end
            default: ;
        endcase
    end

    avis_ram #(.DEPTH(MAX_TRANS), .WIDTH($bits(trans_t))) u_trans_ram (
        .aclk(aclk), .we(tr_we), .waddr(tr_total_reg[TR_AW-1:0]), .wdata(tr_wdata),
        .re(tr_re), .raddr(ptr_reg[TR_AW-1:0]), .rdata(tr_q)
    );

    avis_ram #(.DEPTH(MAX_STATES), .WIDTH(32)) u_value_ram (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
    );

    avis_ram #(.DEPTH(MAX_STATES), .WIDTH(ACT_W)) u_policy_ram (
        .aclk(aclk), .we(pol_we), .waddr(val_waddr), .wdata(pol_wdata),
        .re(s_fire), .raddr(s_data.state_index), .rdata(pol_rdata)
    );

    // sequencer and result path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            tr_total_reg <= '0;
            last_st_reg  <= '0;
            last_act_reg <= '0;
            epochs_reg   <= '0;
            conv_reg     <= 1'b0;
            p1_v_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // result stage to output word
            if (out_free) begin
                m_valid_reg <= p1_v_reg;
                if (p1_v_reg) begin
                    out_reg.state_value   <= p1_rd_reg ? $signed(val_rdata) : 32'sd0;
                    out_reg.policy_action <= p1_rd_reg ? pol_rdata : '0;
                    out_reg.epochs_used   <= epochs_reg;
                    out_reg.converged     <= conv_reg;
                    out_reg.load_error    <= p1_lerr_reg;
                    p1_v_reg              <= 1'b0;
                end
            end

            case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ST_W'(MAX_STATES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        p1_rd_reg   <= s_data.command == CMD_READ;
                        p1_lerr_reg <= (s_data.command == CMD_LOAD) && load_bad;
                        p1_v_reg    <= s_data.command != CMD_SOLVE;
                        case (s_data.command)
                            CMD_CLEAR: begin
                                tr_total_reg <= '0;
                                epochs_reg   <= '0;
                                conv_reg     <= 1'b0;
                                clr_cnt_reg  <= '0;
                                state_reg    <= S_CLR;
                            end
                            CMD_LOAD: begin
                                if (!load_bad) begin
                                    tr_total_reg <= tr_total_reg + 1'b1;
                                    last_st_reg  <= s_data.state_index;
                                    last_act_reg <= s_data.action_index;
                                end
                            end
                            CMD_SOLVE: begin
                                ep_reg    <= '0;
                                state_reg <= S_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWEEP: begin
                    ptr_reg       <= '0;
                    delta_reg     <= '0;
                    grp_on_reg    <= 1'b0;
                    cnt_st_reg    <= '0;
                    cur_reg       <= '0;
                    goal_reg      <= '0;
                    fuel_zero_reg <= 1'b1;
                    state_reg     <= S_RD;
                end
                S_RD: begin
                    if (ptr_reg == tr_total_reg) begin
                        ret_end_reg <= 1'b1;
                        state_reg   <= grp_on_reg ? S_FIN1 : S_END;
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if ({1'b0, tr_q.st} >= ns) begin
                        // sorted table: nothing further is in use
                        ret_end_reg <= 1'b1;
                        state_reg   <= grp_on_reg ? S_FIN1 : S_END;
                    end else if (grp_on_reg && (tr_q.st != grp_st_reg)) begin
                        ret_end_reg <= 1'b0;
                        state_reg   <= S_FIN1;
                    end else if (!grp_on_reg) begin
                        grp_on_reg   <= 1'b1;
                        grp_st_reg   <= tr_q.st;
                        best_any_reg <= 1'b0;
                        run_on_reg   <= 1'b0;
                        state_reg    <= S_ADV;
                    end else begin
                        state_reg <= S_ENT;
                    end
                end
                S_ADV: begin
                    // walk the star digits of the state index up to the group
                    if (cnt_st_reg == grp_st_reg) begin
                        state_reg <= S_ENT;
                    end else begin
                        cnt_st_reg <= cnt_st_reg + 1'b1;
                        if ({1'b0, cur_reg} + 8'd1 == {1'b0, n_eff}) begin
                            cur_reg <= '0;
                            if ({1'b0, goal_reg} + 8'd1 == {1'b0, n_eff}) begin
                                goal_reg      <= '0;
                                fuel_zero_reg <= 1'b0;
                            end else begin
                                goal_reg <= goal_reg + 1'b1;
                            end
                        end else begin
                            cur_reg <= cur_reg + 1'b1;
                        end
                    end
                end
                S_ENT: state_reg <= ent_skip ? S_NXT : S_V1;
                S_V1: begin
                    dv_reg    <= 33'(dv_prod + 49'sd32768 >>> 16);
                    state_reg <= S_V2;
                end
                S_V2: begin
                    term_reg  <= sat34(term_sum);
                    state_reg <= S_V3;
                end
                S_V3: begin
                    prod_reg  <= 34'(pr_prod + 50'sd32768 >>> 16);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (run_on_reg && (run_act_reg == tr_q.act)) begin
                        acc_reg      <= acc_reg + ACC_W'(prod_reg);
                        run_seen_reg <= run_seen_reg || (tr_q.prob != '0);
                    end else begin
                        if (close_upd) begin
                            best_reg     <= acc_sat;
                            best_act_reg <= run_act_reg;
                            best_any_reg <= 1'b1;
                        end
                        acc_reg      <= ACC_W'(prod_reg);
                        run_seen_reg <= tr_q.prob != '0;
                        run_act_reg  <= tr_q.act;
                        run_on_reg   <= 1'b1;
                    end
                    state_reg <= S_NXT;
                end
                S_NXT: begin
                    ptr_reg   <= ptr_reg + 1'b1;
                    state_reg <= S_RD;
                end
                S_FIN1: begin
                    if (close_upd) begin
                        best_reg     <= acc_sat;
                        best_act_reg <= run_act_reg;
                        best_any_reg <= 1'b1;
                    end
                    run_on_reg <= 1'b0;
                    state_reg  <= S_FIN2;
                end
                S_FIN2: begin
                    // old value is on the read port; new one written this cycle
                    if (best_any_reg && (diff_abs > delta_reg)) begin
                        delta_reg <= diff_abs;
                    end
                    grp_on_reg <= 1'b0;
                    state_reg  <= ret_end_reg ? S_END : S_CHK;
                end
                S_END: begin
                    if (sweep_done) begin
                        epochs_reg <= ep_next;
                        conv_reg   <= delta_reg < {17'd0, cfg.tolerance};
                        p1_rd_reg  <= 1'b0;
                        p1_lerr_reg <= 1'b0;
                        p1_v_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end else begin
                        ep_reg    <= ep_next;
                        state_reg <= S_SWEEP;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `AVIS_ASSERT_IMP(a_total_bound, 1'b1, tr_total_reg <= TRC_W'(MAX_TRANS), "table overfilled")
    `AVIS_ASSERT_NXT(a_solve_busy, s_fire && (s_data.command == CMD_SOLVE),
        state_reg == S_SWEEP, "solve not started")
    `AVIS_ASSERT_NXT(a_clear_end,
        (state_reg == S_CLR) && (clr_cnt_reg == ST_W'(MAX_STATES - 1)),
        state_reg == S_IDLE, "clear pass overran")
    `AVIS_ASSERT_IMP(a_fin_group, (state_reg == S_FIN1) || (state_reg == S_FIN2),
        grp_on_reg, "finalize without group")

endmodule

[src/async_value_iteration_solver.sv]
// Channel   Ports              Word type
// input     s_valid/s_ready    avis_pkg::in_word_t  (command, indexes, probability, value)
// result    m_valid/m_ready    avis_pkg::out_word_t (value, policy, epochs, flags)
// config    APB psel..pready   six 32-bit registers at 4*index
//
// Load, write, read and unknown commands are taken in the idle state; a result waits in an
// output register while the next command is taken.
// Solve: each entry in use steps through S_RD, S_CHK, S_ENT, S_V1-S_V3, S_ACC and S_NXT
// (S_ENT straight to S_NXT for an action at or above action_count), each visited state
// through S_FIN1 and S_FIN2, each state index stepped through S_ADV; entries go one at a
// time through the multiply chain and the single value read port.
// Reset and clear zero all 4096 value and policy entries, taking no command meanwhile.
module async_value_iteration_solver (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  avis_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output avis_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import avis_pkg::*;

    cfg_t cfg;

    avis_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    avis_core u_core (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

[sim/async_value_iteration_solver_test.sv]
`timescale 1ns / 1ps

module async_value_iteration_solver_test;
    import avis_pkg::*;

    // Command codes with no function
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int TABLE_DEPTH   = 16384;
    localparam int STORE_DEPTH   = 4096;
    localparam int QUIET_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 50;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    async_value_iteration_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Solver mirror: table, values, policies, counters, registers
    int        tbl_st[TABLE_DEPTH];
    int        tbl_act[TABLE_DEPTH];
    int        tbl_nxt[TABLE_DEPTH];
    int        tbl_prob[TABLE_DEPTH];
    int        tbl_total;
    int        value_mem[STORE_DEPTH];
    int        policy_mem[STORE_DEPTH];
    int        sweeps_done;
    bit        solved_ok;
    int        star_n, states_n, actions_n, disc_q, tol_q, epoch_lim;

    out_word_t pending_words[$];
    int        fail_count;
    int        send_idle;
    int        recv_idle;
    int        words_sent;
    int        quiet_cycles;

    always #2 aclk = ~aclk;

    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint move_cost(int s, int a);
        int n, nn;
        n  = (star_n != 0) ? star_n : 1;
        nn = n * n;
        if (((s % nn) / n) == (s % n) && a == 0) return longint'(COST_GOAL);
        if ((s / nn) == 0) return longint'(COST_FUEL);
        if (a > 0) return longint'(COST_MOVE);
        return 0;
    endfunction

    // One in-place sweep; returns the largest value change
    function automatic longint sweep_values(int ns);
        longint acc[16];
        bit     seen[16];
        longint delta, best, d, term;
        int     ptr, best_a, a;
        bit     any;
        delta = 0;
        ptr = 0;
        for (int s = 0; s < ns; s++) begin
            while (ptr < tbl_total && tbl_st[ptr] < s) ptr++;
            for (int k = 0; k < 16; k++) begin
                acc[k] = 0;
                seen[k] = 0;
            end
            while (ptr < tbl_total && tbl_st[ptr] == s) begin
                a = tbl_act[ptr];
                if (a < actions_n) begin
                    term = clamp32(move_cost(s, a)
                        + round_q16(longint'(disc_q) * longint'(value_mem[tbl_nxt[ptr]])));
                    acc[a] += round_q16(longint'(tbl_prob[ptr]) * term);
                    if (tbl_prob[ptr] != 0) seen[a] = 1;
                end
                ptr++;
            end
            any = 0;
            best = 0;
            best_a = 0;
            for (int k = 0; k < 16; k++) begin
                if (seen[k] && (!any || clamp32(acc[k]) < best)) begin
                    best = clamp32(acc[k]);
                    best_a = k;
                    any = 1;
                end
            end
            if (any) begin
                d = best - longint'(value_mem[s]);
                if (d < 0) d = -d;
                if (d > delta) delta = d;
                value_mem[s] = int'(best);
                policy_mem[s] = best_a;
            end
        end
        return delta;
    endfunction

    // Apply one accepted word to the mirror and give the result it must produce
    function automatic out_word_t predict_result(in_word_t w);
        out_word_t r;
        int        ns, lim, ep;
        longint    delta;
        r = '0;
        case (w.command)
            CMD_CLEAR: begin
                tbl_total = 0;
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    value_mem[i] = 0;
                    policy_mem[i] = 0;
                end
                sweeps_done = 0;
                solved_ok = 0;
            end
            CMD_LOAD: begin
                if (tbl_total >= TABLE_DEPTH
                    || (tbl_total > 0 && (int'(w.state_index) < tbl_st[tbl_total-1]
                        || (int'(w.state_index) == tbl_st[tbl_total-1]
                            && int'(w.action_index) < tbl_act[tbl_total-1])))) begin
                    r.load_error = 1'b1;
                end else begin
                    tbl_st[tbl_total]   = int'(w.state_index);
                    tbl_act[tbl_total]  = int'(w.action_index);
                    tbl_nxt[tbl_total]  = int'(w.succ_state);
                    tbl_prob[tbl_total] = int'(w.probability);
                    tbl_total++;
                end
            end
            CMD_WRITE: value_mem[w.state_index] = w.initial_value;
            CMD_SOLVE: begin
                ns  = (states_n < STORE_DEPTH) ? states_n : STORE_DEPTH;
                lim = (epoch_lim != 0) ? epoch_lim : 1;
                ep  = 0;
                do begin
                    delta = sweep_values(ns);
                    ep++;
                end while (delta >= tol_q && ep < lim);
                sweeps_done = ep & 16'hFFFF;
                solved_ok = (delta < tol_q);
            end
            CMD_READ: begin
                r.state_value = value_mem[w.state_index];
                r.policy_action = 4'(policy_mem[w.state_index]);
            end
            default: ;
        endcase
        r.epochs_used = 16'(sweeps_done);
        r.converged = solved_ok;
        return r;
    endfunction

    // Sender: optional idle gap, then hold the word until taken
    task automatic send_word(logic [2:0] cmd, int si, int ai, int nx, int pr, int iv);
        in_word_t w;
        w.command = cmd;
        w.state_index = 12'(si);
        w.action_index = 4'(ai);
        w.succ_state = 12'(nx);
        w.probability = 17'(pr);
        w.initial_value = iv;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = w;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(predict_result(w));
        words_sent++;
    endtask

    // Hold off the sender until every result is back
    task automatic wait_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        wait_results();
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_STAR_COUNT:   star_n = val & 32'h7F;
            REG_STATE_COUNT:  states_n = val & 32'h1FFF;
            REG_ACTION_COUNT: actions_n = val & 32'h1F;
            REG_DISCOUNT:     disc_q = val & 32'hFFFF;
            REG_TOLERANCE:    tol_q = val & 32'hFFFF;
            REG_MAX_EPOCHS:   epoch_lim = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(int sc, int nst, int ac, int dc, int tl, int me);
        write_reg(REG_STAR_COUNT, sc);
        write_reg(REG_STATE_COUNT, nst);
        write_reg(REG_ACTION_COUNT, ac);
        write_reg(REG_DISCOUNT, dc);
        write_reg(REG_TOLERANCE, tl);
        write_reg(REG_MAX_EPOCHS, me);
    endtask

    task automatic note_mismatch(string field, longint want, longint got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", field, want, got);
    endtask

    // Result checker: oldest expectation against each taken word
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result word %h", m_data);
            end else begin
                e = pending_words.pop_front();
                if (m_data.state_value !== e.state_value)
                    note_mismatch("state_value", e.state_value, m_data.state_value);
                if (m_data.policy_action !== e.policy_action)
                    note_mismatch("policy_action", e.policy_action, m_data.policy_action);
                if (m_data.epochs_used !== e.epochs_used)
                    note_mismatch("epochs_used", e.epochs_used, m_data.epochs_used);
                if (m_data.converged !== e.converged)
                    note_mismatch("converged", e.converged, m_data.converged);
                if (m_data.load_error !== e.load_error)
                    note_mismatch("load_error", e.load_error, m_data.load_error);
            end
        end
    end

    // Receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on quiet cycles
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset state: reads and a solve on an empty table under default registers
    task automatic test_reset_defaults();
        send_word(CMD_READ, 0, 0, 0, 0, 0);
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 63, 0, 0, 0, 0);
    endtask

    // Small problem covering skipped actions, bad loads and unknown commands
    task automatic test_small_problem();
        write_all_regs(2, 8, 2, 32768, 16, 4);
        send_word(CMD_LOAD, 0, 0, 1, 65536, 0);
        send_word(CMD_LOAD, 0, 1, 2, 32768, 0);
        send_word(CMD_LOAD, 0, 1, 3, 32768, 0);
        send_word(CMD_LOAD, 1, 0, 0, 65536, 0);
        send_word(CMD_LOAD, 1, 1, 1, 0, 0);
        send_word(CMD_LOAD, 1, 2, 0, 65536, 0);
        send_word(CMD_LOAD, 0, 3, 0, 65536, 0);
        send_word(CMD_LOAD, 2, 0, 4095, 65536, 0);
        send_word(CMD_LOAD, 9, 0, 0, 65536, 0);
        send_word(CMD_WRITE, 3, 0, 0, 0, 32'h7FFFFFFF);
        send_word(CMD_WRITE, 4095, 0, 0, 0, 32'h80000000);
        send_word(CMD_SPARE_5, 4095, 15, 4095, 131071, -1);
        send_word(CMD_SPARE_6, 0, 0, 0, 0, 0);
        send_word(CMD_SPARE_7, 0, 0, 0, 0, 0);
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        for (int s = 0; s < 5; s++) send_word(CMD_READ, s, 0, 0, 0, 0);
        send_word(CMD_READ, 4095, 0, 0, 0, 0);
    endtask

    // Register extremes, including the top state and limits that act as one
    task automatic test_register_extremes();
        write_all_regs(0, 8191, 31, 65535, 65535, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_word(CMD_LOAD, 4095, 15, 4095, 65536, 0);
        send_word(CMD_WRITE, 4095, 0, 0, 0, 32'h80000000);
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 4095, 0, 0, 0, 0);
        write_all_regs(64, 4096, 16, 0, 65535, 65535);
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 4095, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0);
    endtask

    // Sums driven into both saturation limits, then a load out of order
    task automatic test_sum_saturation();
        write_all_regs(4, 2, 16, 65535, 1, 1);
        send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 1, 0, 0, 0, 32'h7FFFFFFF);
        send_word(CMD_WRITE, 2, 0, 0, 0, 32'h80000000);
        for (int i = 0; i < 48; i++)
            send_word(CMD_LOAD, 0, 0, 1, 131071, 0);
        for (int i = 0; i < 16; i++)
            send_word(CMD_LOAD, 0, 1, 2, 131071, 0);
        send_word(CMD_LOAD, 0, 0, 0, 65536, 0);
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 1, 0, 0, 0, 0);
        send_word(CMD_READ, 2, 0, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
    endtask

    function automatic int pick_prob();
        case ($urandom_range(9))
            0: return 0;
            1, 2: return 65536;
            3: return $urandom_range(131071);
            default: return $urandom_range(65536);
        endcase
    endfunction

    // One random problem: registers, sorted table, values, solve, reads
    task automatic random_problem();
        int sc, ac, reach, nent;
        sc = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
        ac = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 6);
        write_all_regs(($urandom_range(7) == 0) ? 64 * $urandom_range(1) : $urandom_range(1, 6),
            sc, ac, $urandom_range(65535),
            ($urandom_range(3) == 0) ? 0 : ($urandom_range(65535) >> $urandom_range(15)),
            $urandom_range(0, 6));
        if ($urandom_range(1)) send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
        reach = (sc > 0) ? sc : 1;
        for (int s = 0; s <= reach; s++) begin
            if ($urandom_range(3) == 0) continue;
            for (int a = 0; a < 16; a++) begin
                if ((a <= ac) ? ($urandom_range(1) == 0) : ($urandom_range(40) != 0)) continue;
                nent = $urandom_range(1, 2);
                repeat (nent)
                    send_word(CMD_LOAD, s, a,
                        ($urandom_range(9) == 0) ? $urandom_range(4095)
                                                 : $urandom_range(0, reach),
                        pick_prob(), $urandom());
            end
        end
        // noise: loads out of order or far ahead
        if ($urandom_range(2) == 0)
            send_word(CMD_LOAD, $urandom_range(4095), $urandom_range(15),
                $urandom_range(4095), pick_prob(), $urandom());
        repeat ($urandom_range(0, 4))
            send_word(CMD_WRITE, ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                         : $urandom_range(0, reach),
                0, 0, 0, $urandom());
        if ($urandom_range(4) == 0)
            send_word(CMD_SPARE_5 + 3'($urandom_range(2)), $urandom_range(4095),
                $urandom_range(15), $urandom_range(4095), $urandom_range(131071), $urandom());
        send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
        repeat ($urandom_range(3, 8))
            send_word(CMD_READ, ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                        : $urandom_range(0, reach),
                $urandom_range(15), 0, 0, 0);
        if ($urandom_range(2) == 0) begin
            send_word(CMD_SOLVE, 0, 0, 0, 0, 0);
            send_word(CMD_READ, $urandom_range(0, reach), 0, 0, 0, 0);
        end
    endtask

    task automatic test_random_traffic(int count);
        int goal;
        goal = words_sent + count;
        while (words_sent < goal) random_problem();
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        words_sent = 0;
        tbl_total = 0;
        sweeps_done = 0;
        solved_ok = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            value_mem[i] = 0;
            policy_mem[i] = 0;
        end
        star_n = 4;
        states_n = 64;
        actions_n = 4;
        disc_q = 64881;
        tol_q = 1;
        epoch_lim = 1000;
        send_idle = 24;
        recv_idle = 72;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_small_problem();
        test_register_extremes();
        test_sum_saturation();
        send_idle = 72;
        recv_idle = 24;
        test_random_traffic(875);
        wait_results();
        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(875);

        wait_results();
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
